/* rtl/tiled_circle_pattern_shader_defines.svh */
// assertion macros for the tiled circle pattern shader
`ifndef TILED_CIRCLE_PATTERN_SHADER_DEFINES_SVH
`define TILED_CIRCLE_PATTERN_SHADER_DEFINES_SVH
`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define TCPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcps: assertion failed");
// condition must never be seen outside reset
`define TCPS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tcps: forbidden condition seen");
`else
`define TCPS_ASSERT(lbl, clk, rst_n, prop)
`define TCPS_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/tcps_pkg.sv */
// shared types, constants and lookup functions of the tiled circle pattern shader
`default_nettype none
package tcps_pkg;

    // interface widths
    localparam int CFG_W   = 13;
    localparam int PIX_W   = 12;
    localparam int DEP_W   = 16;
    localparam int COL_W   = 8;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 64;

    // canvas register
    localparam logic [CFG_W-1:0] CANVAS_RST = 13'd512;
    localparam logic [CFG_W-1:0] MAX_CANVAS = 13'd4096;

    // fixed point
    localparam int Q_W     = 16;
    localparam int T_W     = 17;
    localparam int X_W     = 19;
    localparam int PAT_W   = 19;
    localparam int N_W     = 11;
    localparam int RECIP_W = 27;
    localparam logic [T_W-1:0] ONE_Q  = 17'd65536;
    localparam logic [17:0]    PI_Q   = 18'd205783;
    localparam logic [17:0]    HALF_S = 18'd32768;
    localparam logic [17:0]    ONE_S  = 18'd65536;

    // tiling divider
    localparam int NL        = 4;
    localparam int DVD_W     = 15;
    localparam int DIV_STEPS = DVD_W + Q_W;
    localparam logic [DVD_W-1:0] ZOOM_A = 15'd7;
    localparam logic [DVD_W-1:0] ZOOM_B = 15'd3;

    // pipeline depth
    localparam int TOP_LAT   = 1;
    localparam int GRID_LAT  = 9;
    localparam int COLOR_LAT = 6;
    localparam int PIPE_LAT  = TOP_LAT + DIV_STEPS + GRID_LAT + COLOR_LAT;

    // circle radius selector
    typedef enum logic [1:0] {
        RAD_023,
        RAD_001,
        RAD_020,
        RAD_005
    } t_rad;

    // smoothstep edges per radius
    localparam logic [X_W-1:0] E0_023 = 19'd10740;
    localparam logic [X_W-1:0] E1_023 = 19'd11870;
    localparam logic [X_W-1:0] E0_001 = 19'd467;
    localparam logic [X_W-1:0] E1_001 = 19'd516;
    localparam logic [X_W-1:0] E0_020 = 19'd9339;
    localparam logic [X_W-1:0] E1_020 = 19'd10322;
    localparam logic [X_W-1:0] E0_005 = 19'd2335;
    localparam logic [X_W-1:0] E1_005 = 19'd2580;

    // reciprocals floor(2^32 / (e1 - e0))
    localparam logic [RECIP_W-1:0] RCP_023 = RECIP_W'((64'd1 << 32) / 64'd1130);
    localparam logic [RECIP_W-1:0] RCP_001 = RECIP_W'((64'd1 << 32) / 64'd49);
    localparam logic [RECIP_W-1:0] RCP_020 = RECIP_W'((64'd1 << 32) / 64'd983);
    localparam logic [RECIP_W-1:0] RCP_005 = RECIP_W'((64'd1 << 32) / 64'd245);

    // colours in Q.16
    localparam logic signed [17:0] COL_A [3] = '{18'sd4915, 18'sd7471, 18'sd21561};
    localparam logic signed [17:0] COL_B [3] = '{18'sd63767, 18'sd55247, 18'sd44237};
    localparam logic signed [17:0] COL_C [3] = '{18'sd49873, 18'sd16187, 18'sd6685};

    function automatic logic [X_W-1:0] edge_lo(input t_rad rad);
        logic [X_W-1:0] e;
        case (rad)
            RAD_023: e = E0_023;
            RAD_001: e = E0_001;
            RAD_020: e = E0_020;
            RAD_005: e = E0_005;
            default: e = E0_023;
        endcase
        return e;
    endfunction

    function automatic logic [X_W-1:0] edge_hi(input t_rad rad);
        logic [X_W-1:0] e;
        case (rad)
            RAD_023: e = E1_023;
            RAD_001: e = E1_001;
            RAD_020: e = E1_020;
            RAD_005: e = E1_005;
            default: e = E1_023;
        endcase
        return e;
    endfunction

    function automatic logic [RECIP_W-1:0] edge_recip(input t_rad rad);
        logic [RECIP_W-1:0] r;
        case (rad)
            RAD_023: r = RCP_023;
            RAD_001: r = RCP_001;
            RAD_020: r = RCP_020;
            RAD_005: r = RCP_005;
            default: r = RCP_023;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/tcps_div.sv */
// pipelined restoring divider giving the Q0.16 tile coordinate for four lanes
`default_nettype none
module tcps_div
    import tcps_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [NL-1:0][DVD_W-1:0]   i_dvd,
    input  wire logic [CFG_W-1:0]           i_c,
    output logic      [NL-1:0][Q_W-1:0]     o_q
);

    logic [CFG_W-1:0]          r_c   [DIV_STEPS];
    logic [NL-1:0][DVD_W-1:0]  r_dvd [DIV_STEPS];
    logic [NL-1:0][11:0]       r_rem [DIV_STEPS];
    logic [NL-1:0][Q_W-1:0]    r_q   [DIV_STEPS];

    logic [CFG_W-1:0]          w_c   [DIV_STEPS];
    logic [NL-1:0][DVD_W-1:0]  w_dvd [DIV_STEPS];
    logic [NL-1:0][11:0]       w_rem [DIV_STEPS];
    logic [NL-1:0][Q_W-1:0]    w_q   [DIV_STEPS];

    logic [NL-1:0][DVD_W-1:0]  n_dvd [DIV_STEPS];
    logic [NL-1:0][11:0]       n_rem [DIV_STEPS];
    logic [NL-1:0][Q_W-1:0]    n_q   [DIV_STEPS];

    genvar gs;
    generate
        for (gs = 0; gs < DIV_STEPS; gs++) begin : g_step
            // stage inputs
            if (gs == 0) begin : g_first
                assign w_c[gs]   = i_c;
                assign w_dvd[gs] = i_dvd;
                assign w_rem[gs] = '0;
                assign w_q[gs]   = '0;
            end else begin : g_next
                assign w_c[gs]   = r_c[gs-1];
                assign w_dvd[gs] = r_dvd[gs-1];
                assign w_rem[gs] = r_rem[gs-1];
                assign w_q[gs]   = r_q[gs-1];
            end

            // one quotient bit per lane: the dividend shifts out, zeros fill the fraction
            always_comb begin
                logic [12:0] sh;
                for (int l = 0; l < NL; l++) begin
                    sh = {w_rem[gs][l], w_dvd[gs][l][DVD_W-1]};
                    n_dvd[gs][l] = {w_dvd[gs][l][DVD_W-2:0], 1'b0};
                    if (sh >= w_c[gs]) begin
                        n_rem[gs][l] = 12'(sh - w_c[gs]);
                        n_q[gs][l]   = {w_q[gs][l][Q_W-2:0], 1'b1};
                    end else begin
                        n_rem[gs][l] = 12'(sh);
                        n_q[gs][l]   = {w_q[gs][l][Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c[gs]   <= w_c[gs];
                    r_dvd[gs] <= n_dvd[gs];
                    r_rem[gs] <= n_rem[gs];
                    r_q[gs]   <= n_q[gs];
                end
            end
        end
    endgenerate

    assign o_q = r_q[DIV_STEPS-1];

endmodule
`default_nettype wire

/* rtl/tcps_smooth.sv */
// five-stage smoothstep edge giving one circle's coverage
`default_nettype none
module tcps_smooth
    import tcps_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_en,
    input  wire t_rad             i_rad,
    input  wire logic [X_W-1:0]   i_x,
    output logic      [T_W-1:0]   o_cov
);

    logic [X_W-1:0]     w_e0;
    logic [X_W-1:0]     w_e1;
    logic [N_W-1:0]     w_den;
    logic [RECIP_W-1:0] w_rcp;

    assign w_e0  = edge_lo(i_rad);
    assign w_e1  = edge_hi(i_rad);
    assign w_den = N_W'(w_e1 - w_e0);
    assign w_rcp = edge_recip(i_rad);

    // stage 1: edge compare and offset
    logic           r_lo1, r_hi1;
    logic [N_W-1:0] r_n1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo1 <= (i_x <= w_e0);
            r_hi1 <= (i_x >= w_e1);
            r_n1  <= N_W'(i_x - w_e0);
        end
    end

    // stage 2: quotient estimate by reciprocal
    logic [N_W+RECIP_W-1:0] w_prod2;
    logic                   r_lo2, r_hi2;
    logic [N_W-1:0]         r_n2;
    logic [T_W-1:0]         r_qe2;
    assign w_prod2 = (N_W+RECIP_W)'(r_n1) * (N_W+RECIP_W)'(w_rcp);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo2 <= r_lo1;
            r_hi2 <= r_hi1;
            r_n2  <= r_n1;
            r_qe2 <= w_prod2[Q_W+T_W-1:Q_W];
        end
    end

    // stage 3: one correction step, then the clamp to [0,1]
    logic [27:0]    w_rem3;
    logic [T_W-1:0] n_t3;
    logic [T_W-1:0] r_t3;
    assign w_rem3 = {1'b0, r_n2, 16'b0} - (28'(r_qe2) * 28'(w_den));
    always_comb begin
        if (r_lo2) begin
            n_t3 = '0;
        end else if (r_hi2) begin
            n_t3 = ONE_Q;
        end else if (w_rem3 >= 28'(w_den)) begin
            n_t3 = r_qe2 + T_W'(1);
        end else begin
            n_t3 = r_qe2;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t3 <= n_t3;
        end
    end

    // stage 4: t squared and the 3 - 2t factor
    logic [33:0]    w_sq4;
    logic [T_W-1:0] r_s2;
    logic [17:0]    r_w4;
    assign w_sq4 = 34'(r_t3) * 34'(r_t3);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= w_sq4[Q_W+T_W-1:Q_W];
            r_w4 <= 18'd196608 - {r_t3, 1'b0};
        end
    end

    // stage 5: smoothstep and its complement
    logic [34:0] w_p5;
    logic [17:0] w_ss5;
    logic [T_W-1:0] r_cov;
    assign w_p5  = 35'(r_s2) * 35'(r_w4);
    assign w_ss5 = w_p5[33:16];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cov <= T_W'(18'(ONE_Q) - w_ss5);
        end
    end

    assign o_cov = r_cov;

endmodule
`default_nettype wire

/* rtl/tcps_grid.sv */
// four-circle pattern of one tile grid for two radii
`default_nettype none
module tcps_grid
    import tcps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire t_rad               i_rad_a,
    input  wire t_rad               i_rad_b,
    input  wire logic [Q_W-1:0]     i_sx,
    input  wire logic [Q_W-1:0]     i_sy,
    output logic      [PAT_W-1:0]   o_pat_a,
    output logic      [PAT_W-1:0]   o_pat_b
);

    // stage 1: squared distances along each axis to 0, 0.5 and 1
    logic signed [17:0] w_x0, w_xh, w_x1, w_y0, w_yh, w_y1;
    logic signed [35:0] w_sxx0, w_sxxh, w_sxx1, w_syy0, w_syyh, w_syy1;
    logic [32:0] r_sx0, r_sxh, r_sx1, r_sy0, r_syh, r_sy1;
    assign w_x0 = $signed({2'b0, i_sx});
    assign w_xh = $signed({2'b0, i_sx} - HALF_S);
    assign w_x1 = $signed({2'b0, i_sx} - ONE_S);
    assign w_y0 = $signed({2'b0, i_sy});
    assign w_yh = $signed({2'b0, i_sy} - HALF_S);
    assign w_y1 = $signed({2'b0, i_sy} - ONE_S);
    assign w_sxx0 = w_x0 * w_x0;
    assign w_sxxh = w_xh * w_xh;
    assign w_sxx1 = w_x1 * w_x1;
    assign w_syy0 = w_y0 * w_y0;
    assign w_syyh = w_yh * w_yh;
    assign w_syy1 = w_y1 * w_y1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx0 <= 33'(w_sxx0);
            r_sxh <= 33'(w_sxxh);
            r_sx1 <= 33'(w_sxx1);
            r_sy0 <= 33'(w_syy0);
            r_syh <= 33'(w_syyh);
            r_sy1 <= 33'(w_syy1);
        end
    end

    // stage 2: squared radius per circle, centres at the edge midpoints
    logic [33:0] w_sum [4];
    logic [17:0] r_d [4];
    assign w_sum[0] = 34'(r_sxh) + 34'(r_sy1);
    assign w_sum[1] = 34'(r_sxh) + 34'(r_sy0);
    assign w_sum[2] = 34'(r_sx1) + 34'(r_syh);
    assign w_sum[3] = 34'(r_sx0) + 34'(r_syh);
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_d[k] <= w_sum[k][33:16];
            end
        end
    end

    // stage 3: scale by pi
    logic [35:0]    w_px [4];
    logic [X_W-1:0] r_x  [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_px[k] = 36'(r_d[k]) * 36'(PI_Q);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_x[k] <= w_px[k][Q_W+X_W-1:Q_W];
            end
        end
    end

    // stages 4 to 8: smoothstep edges
    logic [T_W-1:0] w_cov_a [4];
    logic [T_W-1:0] w_cov_b [4];
    genvar gk;
    generate
        for (gk = 0; gk < 4; gk++) begin : g_circ
            tcps_smooth u_smooth_a (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rad (i_rad_a),
                .i_x   (r_x[gk]),
                .o_cov (w_cov_a[gk])
            );
            tcps_smooth u_smooth_b (
                .i_clk (i_clk),
                .i_en  (i_en),
                .i_rad (i_rad_b),
                .i_x   (r_x[gk]),
                .o_cov (w_cov_b[gk])
            );
        end
    endgenerate

    // stage 9: pattern sums
    logic [PAT_W-1:0] r_pat_a, r_pat_b;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pat_a <= PAT_W'(w_cov_a[0]) + PAT_W'(w_cov_a[1])
                     + PAT_W'(w_cov_a[2]) + PAT_W'(w_cov_a[3]);
            r_pat_b <= PAT_W'(w_cov_b[0]) + PAT_W'(w_cov_b[1])
                     + PAT_W'(w_cov_b[2]) + PAT_W'(w_cov_b[3]);
        end
    end

    assign o_pat_a = r_pat_a;
    assign o_pat_b = r_pat_b;

endmodule
`default_nettype wire

/* rtl/tcps_color.sv */
// colour blend, clamp and 8-bit scaling of three channels
`default_nettype none
module tcps_color
    import tcps_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic [PAT_W-1:0]   i_p023,
    input  wire logic [PAT_W-1:0]   i_p001,
    input  wire logic [PAT_W-1:0]   i_p020,
    input  wire logic [PAT_W-1:0]   i_p005,
    output logic      [COL_W-1:0]   o_ch [3]
);

    // stage 1: blend weights
    logic signed [19:0] r_t1;
    logic [PAT_W-1:0]   r_t2_1, r_sub_1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t1    <= $signed({1'b0, i_p023}) - $signed({1'b0, i_p001});
            r_t2_1  <= i_p020;
            r_sub_1 <= i_p005;
        end
    end

    // stage 2: (b - a) * t1
    logic signed [37:0] r_p1 [3];
    logic [PAT_W-1:0]   r_t2_2, r_sub_2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_p1[ch] <= 38'(COL_B[ch] - COL_A[ch]) * 38'(r_t1);
            end
            r_t2_2  <= r_t2_1;
            r_sub_2 <= r_sub_1;
        end
    end

    // stage 3: first mix minus colour c
    logic signed [20:0] r_d1 [3];
    logic [PAT_W-1:0]   r_t2_3, r_sub_3;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_d1[ch] <= 21'(38'(COL_A[ch] - COL_C[ch]) + (r_p1[ch] >>> 16));
            end
            r_t2_3  <= r_t2_2;
            r_sub_3 <= r_sub_2;
        end
    end

    // stage 4: (c1 - c) * t2
    logic signed [39:0] r_p2 [3];
    logic [PAT_W-1:0]   r_sub_4;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_p2[ch] <= 40'(r_d1[ch]) * 40'($signed({1'b0, r_t2_3}));
            end
            r_sub_4 <= r_sub_3;
        end
    end

    // stage 5: second mix, subtract, clamp to [0,1]
    logic signed [23:0] w_v [3];
    logic [T_W-1:0]     r_v5 [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_v[ch] = 24'(COL_C[ch]) + 24'(r_p2[ch] >>> 16)
                    - $signed({5'b0, r_sub_4});
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (w_v[ch] < 0) begin
                    r_v5[ch] <= '0;
                end else if (w_v[ch] > $signed(24'(ONE_Q))) begin
                    r_v5[ch] <= ONE_Q;
                end else begin
                    r_v5[ch] <= T_W'(w_v[ch]);
                end
            end
        end
    end

    // stage 6: scale to 8 bits with rounding
    logic [25:0]      w_sc [3];
    logic [COL_W-1:0] r_ch [3];
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            w_sc[ch] = (26'(r_v5[ch]) << 8) - 26'(r_v5[ch]) + 26'd32768;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ch = 0; ch < 3; ch++) begin
                r_ch[ch] <= w_sc[ch][23:16];
            end
        end
    end

    assign o_ch = r_ch;

endmodule
`default_nettype wire

/* rtl/tiled_circle_pattern_shader.sv */
// top level: stream ports, canvas register, pipeline control and output skid
// every stage advances together on a common enable, held low while the skid is full
// throughput: one pixel per cycle while the skid entry is empty
// the depth is set by the 31-step tiling divider, the smoothstep units and the colour blend
// a two-entry output register keeps the pipeline moving into a stall until both are full
// reset (synchronous, active low) empties the pipeline and sets the canvas side to 512
`default_nettype none
`include "tiled_circle_pattern_shader_defines.svh"
module tiled_circle_pattern_shader
    import tcps_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wen,
    input  wire logic [CFG_W-1:0]  i_cfg_wdata,
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // pixel_x[11:0], pixel_y[23:12], depth_in[39:24]
    input  wire logic [IN_W-1:0]   i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    // out_x[11:0], out_y[23:12], red[31:24], green[39:32], blue[47:40], depth_out[63:48]
    output logic [OUT_W-1:0]       o_m_axis_tdata
);

    localparam int LAST = PIPE_LAT - 1;

    logic w_en, w_acc, w_take;
    logic r_out_valid, r_skid_valid;

    assign w_en            = !r_skid_valid;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;
    assign w_take          = r_out_valid && i_m_axis_tready;

    // canvas register
    logic [CFG_W-1:0] r_canvas;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas <= CANVAS_RST;
        end else if (i_cfg_wen) begin
            r_canvas <= i_cfg_wdata;
        end
    end

    // effective canvas side
    logic [CFG_W-1:0] w_c;
    always_comb begin
        if (r_canvas == '0) begin
            w_c = CFG_W'(1);
        end else if (r_canvas > MAX_CANVAS) begin
            w_c = MAX_CANVAS;
        end else begin
            w_c = r_canvas;
        end
    end

    // input fields
    logic [PIX_W-1:0] w_px, w_py;
    logic [DEP_W-1:0] w_dep;
    assign w_px  = i_s_axis_tdata[11:0];
    assign w_py  = i_s_axis_tdata[23:12];
    assign w_dep = i_s_axis_tdata[39:24];

    // entry stage: zoomed coordinates and canvas side
    logic [NL-1:0][DVD_W-1:0] r_dvd;
    logic [CFG_W-1:0]         r_c;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dvd[0] <= DVD_W'(w_px) * ZOOM_A;
            r_dvd[1] <= DVD_W'(w_py) * ZOOM_A;
            r_dvd[2] <= DVD_W'(w_px) * ZOOM_B;
            r_dvd[3] <= DVD_W'(w_py) * ZOOM_B;
            r_c      <= w_c;
        end
    end

    // valid bits and pass-through fields along the pipeline
    logic [PIPE_LAT-1:0] r_v;
    logic [PIX_W-1:0]    r_px  [PIPE_LAT];
    logic [PIX_W-1:0]    r_py  [PIPE_LAT];
    logic [DEP_W-1:0]    r_dep [PIPE_LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[PIPE_LAT-2:0], w_acc};
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px[0]  <= w_px;
            r_py[0]  <= w_py;
            r_dep[0] <= w_dep;
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_px[s]  <= r_px[s-1];
                r_py[s]  <= r_py[s-1];
                r_dep[s] <= r_dep[s-1];
            end
        end
    end

    // tile coordinates
    logic [NL-1:0][Q_W-1:0] w_tc;
    tcps_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_dvd (r_dvd),
        .i_c   (r_c),
        .o_q   (w_tc)
    );

    // patterns on the zoom 7 and zoom 3 grids
    logic [PAT_W-1:0] w_p023, w_p001, w_p020, w_p005;
    tcps_grid u_grid_fine (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_rad_a (RAD_023),
        .i_rad_b (RAD_001),
        .i_sx    (w_tc[0]),
        .i_sy    (w_tc[1]),
        .o_pat_a (w_p023),
        .o_pat_b (w_p001)
    );
    tcps_grid u_grid_coarse (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_rad_a (RAD_020),
        .i_rad_b (RAD_005),
        .i_sx    (w_tc[2]),
        .i_sy    (w_tc[3]),
        .o_pat_a (w_p020),
        .o_pat_b (w_p005)
    );

    // colour
    logic [COL_W-1:0] w_ch [3];
    tcps_color u_color (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_p023 (w_p023),
        .i_p001 (w_p001),
        .i_p020 (w_p020),
        .i_p005 (w_p005),
        .o_ch   (w_ch)
    );

    // result at the pipeline end
    logic [OUT_W-1:0] w_res;
    assign w_res = {r_dep[LAST], w_ch[2], w_ch[1], w_ch[0], r_py[LAST], r_px[LAST]};

    // output register and skid entry
    logic [OUT_W-1:0] r_out, r_skid;
    logic w_arrive, w_block, w_drain;
    assign w_arrive = w_en && r_v[LAST];
    assign w_block  = w_arrive && r_out_valid && !w_take;
    assign w_drain  = r_skid_valid && w_take;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_arrive && (!r_out_valid || w_take)) begin
                r_out_valid <= 1'b1;
            end else if (w_arrive) begin
                r_skid_valid <= 1'b1;
            end else if (w_take && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_arrive && (!r_out_valid || w_take)) begin
            r_out <= w_res;
        end else if (w_arrive) begin
            r_skid <= w_res;
        end else if (w_take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    `TCPS_ASSERT_NEVER(a_skid_without_out, i_clk, i_rst_n, r_skid_valid && !r_out_valid)
    `TCPS_ASSERT(a_accept_enters, i_clk, i_rst_n, w_acc |=> r_v[0])
    `TCPS_ASSERT(a_blocked_to_skid, i_clk, i_rst_n, w_block |=> r_skid_valid)
    `TCPS_ASSERT(a_skid_drains, i_clk, i_rst_n, w_drain |=> (r_out_valid && !r_skid_valid))

endmodule
`default_nettype wire

/* sim/tiled_circle_pattern_shader_tb.sv */
// self-checking testbench for the tiled circle pattern shader
`timescale 1ns / 100ps
`default_nettype none
module tiled_circle_pattern_shader_tb;
    import tcps_pkg::*;

    localparam int LAT_WAIT    = 80;
    localparam longint LIMIT_CYC = 400000;

    typedef struct packed {
        logic [15:0] depth;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] py;
        logic [11:0] px;
    } t_pix_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_wen = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic i_s_axis_tvalid = 1'b0;
    logic o_s_axis_tready;
    logic [IN_W-1:0] i_s_axis_tdata = '0;
    logic o_m_axis_tvalid;
    logic i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0] o_m_axis_tdata;

    // shadow copy of the canvas register
    logic [CFG_W-1:0] canvas_shadow;
    t_pix_out expected_pixels[$];
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_cycles = 0;
    int  n_errors = 0;
    int  n_checked = 0;
    longint cyc = 0;

    tiled_circle_pattern_shader DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // floor of a Q.16 product
    function automatic longint qfloor(input longint p);
        return p >>> 16;
    endfunction

    function automatic longint tile_pos(input longint p, input longint z, input longint c);
        return (((p * z) % c) << 16) / c;
    endfunction

    function automatic longint edge_lo_val(input t_rad rad, input int hi);
        case (rad)
            RAD_023: return hi ? 11870 : 10740;
            RAD_001: return hi ? 516 : 467;
            RAD_020: return hi ? 10322 : 9339;
            default: return hi ? 2580 : 2335;
        endcase
    endfunction

    // one smoothstep circle coverage
    function automatic longint circle_cover(input longint sx, input longint sy,
                                            input int k, input t_rad rad);
        longint ox, oy, d, x, e0, e1, t, s2, ss;
        case (k)
            0: begin ox = -32768; oy = -65536; end
            1: begin ox = -32768; oy = 0; end
            2: begin ox = -65536; oy = -32768; end
            default: begin ox = 0; oy = -32768; end
        endcase
        ox += sx;
        oy += sy;
        d = qfloor(ox * ox + oy * oy);
        x = qfloor(d * 205783);
        e0 = edge_lo_val(rad, 0);
        e1 = edge_lo_val(rad, 1);
        if (x <= e0) t = 0;
        else if (x >= e1) t = 65536;
        else t = ((x - e0) << 16) / (e1 - e0);
        s2 = qfloor(t * t);
        ss = qfloor(s2 * (196608 - 2 * t));
        return 65536 - ss;
    endfunction

    function automatic longint four_circles(input longint sx, input longint sy,
                                            input t_rad rad);
        longint s;
        s = 0;
        for (int k = 0; k < 4; k++) s += circle_cover(sx, sy, k, rad);
        return s;
    endfunction

    function automatic logic [7:0] chan_byte(input longint v);
        if (v < 0) v = 0;
        if (v > 65536) v = 65536;
        return 8'((v * 255 + 32768) >>> 16);
    endfunction

    // predicted shaded pixel
    function automatic t_pix_out shade_pixel(input logic [11:0] px, input logic [11:0] py,
                                             input logic [15:0] dep);
        longint c, g1x, g1y, g2x, g2y, t1, t2, sub, c1, v;
        longint ca[3], cb[3], cc[3];
        logic [7:0] ch[3];
        t_pix_out r;
        ca = '{4915, 7471, 21561};
        cb = '{63767, 55247, 44237};
        cc = '{49873, 16187, 6685};
        c = canvas_shadow;
        if (c == 0) c = 1;
        if (c > 4096) c = 4096;
        g1x = tile_pos(px, 7, c); g1y = tile_pos(py, 7, c);
        g2x = tile_pos(px, 3, c); g2y = tile_pos(py, 3, c);
        t1 = four_circles(g1x, g1y, RAD_023) - four_circles(g1x, g1y, RAD_001);
        t2 = four_circles(g2x, g2y, RAD_020);
        sub = four_circles(g2x, g2y, RAD_005);
        for (int i = 0; i < 3; i++) begin
            c1 = ca[i] + qfloor((cb[i] - ca[i]) * t1);
            v = cc[i] + qfloor((c1 - cc[i]) * t2) - sub;
            ch[i] = chan_byte(v);
        end
        r.px = px; r.py = py; r.depth = dep;
        r.red = ch[0]; r.green = ch[1]; r.blue = ch[2];
        return r;
    endfunction

    // drive one pixel transaction and log its expected colour
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                              input logic [15:0] dep);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {dep, py, px};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_pixels.push_back(shade_pixel(px, py, dep));
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic drain_pipe();
        while (expected_pixels.size() != 0) @(negedge i_clk);
        repeat (LAT_WAIT) @(negedge i_clk);
    endtask

    task automatic write_canvas(input logic [CFG_W-1:0] val);
        drain_pipe();
        i_cfg_wen <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_wen <= 1'b0;
        canvas_shadow = val;
    endtask

    task automatic send_random(input int n, input int csz);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9, 0) < 7)
                send_pixel(12'($urandom_range(csz - 1, 0)),
                           12'($urandom_range(csz - 1, 0)), 16'($urandom));
            else
                send_pixel(12'($urandom), 12'($urandom), 16'($urandom));
        end
    endtask

    // directed corners, zero and oversized canvas
    task automatic test_directed();
        send_pixel(12'd0, 12'd0, 16'd0);
        send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
        send_pixel(12'd0, 12'hFFF, 16'h8000);
        send_pixel(12'd256, 12'd256, 16'h1234);
        send_pixel(12'd36, 12'd36, 16'd1);
        send_pixel(12'd600, 12'd1000, 16'hAAAA);
        write_canvas(13'd0);
        send_pixel(12'd5, 12'd9, 16'h5555);
        send_pixel(12'hFFF, 12'd0, 16'd7);
        write_canvas(13'd1);
        send_pixel(12'd3, 12'd4, 16'd9);
        write_canvas(13'h1FFF);
        send_pixel(12'd100, 12'd4000, 16'd11);
        send_pixel(12'hFFF, 12'hFFF, 16'd12);
        write_canvas(13'd4096);
        send_pixel(12'd585, 12'd1755, 16'd13);
        write_canvas(13'd4097);
        send_pixel(12'd585, 12'd1755, 16'd14);
    endtask

    // random pixels over canvas settings and idle mixes
    task automatic test_random_sweep();
        logic [CFG_W-1:0] sizes[6];
        sizes = '{13'd512, 13'd37, 13'd4096, 13'd1, 13'd255, 13'd8191};
        for (int p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 37 : (p == 1) ? 60 : 0;
            recv_idle_pct = (p == 0) ? 60 : (p == 1) ? 37 : 0;
            for (int s = 0; s < 6; s++) begin
                write_canvas(sizes[s]);
                send_random(64, (sizes[s] > 4096 || sizes[s] == 0) ? 4096 : sizes[s]);
            end
            write_canvas(13'($urandom_range(4096, 2)));
            send_random(30, 4096);
        end
    endtask

    // long receiver stall with sender pushing, then a full drain and a further random burst
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = 150;
        send_random(120, 512);
        drain_pipe();
        send_random(20, 4096);
    endtask

    // receiver readiness, with an optional long hold
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pix_out got, exp_pix;
        cyc <= cyc + 1;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected transaction, actual %h", $time, got);
                n_errors++;
            end else begin
                exp_pix = expected_pixels.pop_front();
                n_checked++;
                if (got !== exp_pix) begin
                    $display("%0t: mismatch expected x=%0d y=%0d rgb=%0d,%0d,%0d d=%h",
                             $time, exp_pix.px, exp_pix.py, exp_pix.red, exp_pix.green,
                             exp_pix.blue, exp_pix.depth);
                    $display("%0t:          actual x=%0d y=%0d rgb=%0d,%0d,%0d d=%h",
                             $time, got.px, got.py, got.red, got.green, got.blue,
                             got.depth);
                    n_errors++;
                end
            end
        end
        if (cyc > LIMIT_CYC) begin
            $display("timeout after %0d cycles", cyc);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        canvas_shadow = CANVAS_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random_sweep();
        test_backpressure();
        drain_pipe();
        $display("checked %0d shaded pixels across canvas sizes 0..8191,", n_checked);
        $display("with random idles on both sides and a long output stall");
        if (n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
